@@ hdl/cds_pkg.sv @@
// Shared constants and types for the card deck shuffler.
`timescale 1ns / 1ps
`default_nettype none
package cds_pkg;

  localparam int unsigned SUITS     = 4;
  localparam int unsigned RANKS     = 13;
  localparam int unsigned DECK_SIZE = SUITS * RANKS;
  localparam int unsigned ADDR_W    = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
  localparam int unsigned DIV_W     = $clog2(DECK_SIZE + 1);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CNT_W     = $clog2(WORD_W);
  localparam int unsigned FIELD_W   = 6;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DIV_W-1:0]   dvs_t;
  typedef logic [DIV_W:0]     trial_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam addr_t TOP_POS  = addr_t'(DECK_SIZE - 1);
  localparam cnt_t  CNT_LAST = cnt_t'(WORD_W - 1);

endpackage
`default_nettype wire

@@ hdl/cds_if.sv @@
// Valid/ready channel interfaces for the card deck shuffler.
`timescale 1ns / 1ps
`default_nettype none
interface cds_in_if;
  logic                 valid;
  logic                 ready;
  cds_pkg::word_t       random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface cds_out_if;
  logic                 valid;
  logic                 ready;
  cds_pkg::field_t      card;
  cds_pkg::field_t      slot;
  logic                 pass_done;

  modport source (output valid, output card, output slot, output pass_done, input ready);
  modport sink   (input valid, input card, input slot, input pass_done, output ready);
endinterface
`default_nettype wire

@@ hdl/card_deck_shuffler.sv @@
// Top level of the card deck shuffler: Fisher-Yates steps on a stored deck.
//
// Each random word drives one Fisher-Yates step on a 52-card deck held in a
// RAM: j = word mod (position+1), entries j and position are swapped and the
// card fixed at position is emitted; the step at position 1 also emits
// position 0 with pass_done set, and the next pass starts again at the top.
// A step runs through the bit-serial restoring modulo unit (one word bit per
// cycle), then a read and two writes on the single RAM write port, and then
// loads the output register. The step at position 1 passes through ST_RD0
// and ST_OUT2 for its second result. Input is accepted only while the
// sequencer is idle, which it enters in the cycle after the last result of
// a step is loaded. A waiting result holds the next step only in its output
// states. After reset the deck reads as card k at entry k, tracked by
// per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module card_deck_shuffler (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cds_in_if.sink     in_i,
  cds_out_if.source  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_RD, ST_WR1, ST_WR2, ST_OUT1, ST_RD0, ST_OUT2
  } state_e;

  state_e                         state_q;
  cds_pkg::word_t                 word_q;
  cds_pkg::dvs_t                  rem_q;
  cds_pkg::cnt_t                  cnt_q;
  cds_pkg::addr_t                 pos_q;
  cds_pkg::addr_t                 j_q;
  cds_pkg::addr_t                 held_q;
  logic [cds_pkg::DECK_SIZE-1:0]  valid_q;

  cds_pkg::addr_t                 ra_a_d, ra_a_q, ra_b_q;
  logic                           va_q, vb_q;
  cds_pkg::addr_t                 rd_a, rd_b, card_a, card_b;

  logic                           we;
  cds_pkg::addr_t                 wa, wd;

  cds_pkg::dvs_t                  divisor;
  cds_pkg::trial_t                trial, trial_sub;
  cds_pkg::dvs_t                  rem_d;

  logic                           out_valid_q;
  cds_pkg::field_t                out_card_q, out_slot_q;
  logic                           out_last_q;
  logic                           out_free;
  logic                           out_load;

  // modulo step: shift in one word bit, subtract divisor when it fits
  assign divisor   = cds_pkg::dvs_t'(pos_q) + cds_pkg::dvs_t'(1);
  assign trial     = {rem_q, word_q[cds_pkg::WORD_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign rem_d     = (trial >= {1'b0, divisor}) ? cds_pkg::dvs_t'(trial_sub)
                                                : cds_pkg::dvs_t'(trial);

  assign ra_a_d = (state_q == ST_RD) ? j_q : '0;

  always_comb begin
    we = 1'b0;
    wa = j_q;
    wd = card_b;
    case (state_q)
      ST_WR1: begin
        we = 1'b1;
        wa = j_q;
        wd = card_b;
      end
      ST_WR2: begin
        we = 1'b1;
        wa = pos_q;
        wd = held_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  cds_ram #(
    .WIDTH (cds_pkg::ADDR_W),
    .DEPTH (cds_pkg::DECK_SIZE)
  ) u_deck (
    .clk_i  (clk_i),
    .we_i   (we),
    .wa_i   (wa),
    .wd_i   (wd),
    .ra_a_i (ra_a_d),
    .ra_b_i (pos_q),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // unwritten entries hold their own index
  assign card_a = va_q ? rd_a : ra_a_q;
  assign card_b = vb_q ? rd_b : ra_b_q;

  always_ff @(posedge clk_i) begin
    ra_a_q <= ra_a_d;
    ra_b_q <= pos_q;
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = out_free && ((state_q == ST_OUT1) || (state_q == ST_OUT2));
  assign in_i.ready = (state_q == ST_IDLE);

  assign out_o.valid     = out_valid_q;
  assign out_o.card      = out_card_q;
  assign out_o.slot      = out_slot_q;
  assign out_o.pass_done = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= cds_pkg::TOP_POS;
      valid_q     <= '0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
      word_q      <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      j_q         <= '0;
      held_q      <= '0;
      out_card_q  <= '0;
      out_slot_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      va_q <= valid_q[ra_a_d];
      vb_q <= valid_q[pos_q];
      if (we) begin
        valid_q[wa] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            word_q  <= in_i.random_word;
            rem_q   <= '0;
            cnt_q   <= cds_pkg::CNT_LAST;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= rem_d;
          word_q <= {word_q[cds_pkg::WORD_W-2:0], 1'b0};
          cnt_q  <= cnt_q - cds_pkg::cnt_t'(1);
          if (cnt_q == '0) begin
            j_q     <= cds_pkg::addr_t'(rem_d);
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_WR1;
        end
        ST_WR1: begin
          held_q  <= card_a;
          state_q <= ST_WR2;
        end
        ST_WR2: begin
          state_q <= ST_OUT1;
        end
        ST_OUT1: begin
          if (out_free) begin
            out_card_q  <= cds_pkg::field_t'(held_q);
            out_slot_q  <= cds_pkg::field_t'(pos_q);
            out_last_q  <= (pos_q == '0);
            if (pos_q == '0) begin
              pos_q   <= cds_pkg::TOP_POS;
              state_q <= ST_IDLE;
            end else if (pos_q == cds_pkg::addr_t'(1)) begin
              state_q <= ST_RD0;
            end else begin
              pos_q   <= pos_q - cds_pkg::addr_t'(1);
              state_q <= ST_IDLE;
            end
          end
        end
        ST_RD0: begin
          state_q <= ST_OUT2;
        end
        ST_OUT2: begin
          if (out_free) begin
            out_card_q  <= cds_pkg::field_t'(card_a);
            out_slot_q  <= '0;
            out_last_q  <= 1'b1;
            pos_q       <= cds_pkg::TOP_POS;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/cds_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module cds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wa_i,
  input  wire logic [WIDTH-1:0]                             wd_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra_a_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra_b_i,
  output logic      [WIDTH-1:0]                             rd_a_o,
  output logic      [WIDTH-1:0]                             rd_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    rd_a_o <= mem_q[ra_a_i];
    rd_b_o <= mem_q[ra_b_i];
  end

endmodule
`default_nettype wire

@@ sim/card_deck_shuffler_tb.sv @@
// Self-checking testbench for the card deck shuffler: directed table, then random shuffle steps.
`timescale 1ns / 1ps
`default_nettype none
module card_deck_shuffler_tb;

  localparam int unsigned RANDOM_ITEMS = 1934;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned MAX_GAP      = 14;
  localparam int unsigned SHOW_MAX     = 10;

  typedef struct packed {
    cds_pkg::field_t card;
    cds_pkg::field_t slot;
    logic            pass_done;
  } deal_t;

  typedef struct packed {
    cds_pkg::word_t word;
    logic           typed;
    deal_t          first;
  } stim_row_t;

  // Typed rows: fresh deck, then all-ones (divisible by 51, so j = 0), then j equal to position.
  localparam int DIR_N = 17;
  localparam stim_row_t DIR_TAB [DIR_N] = '{
    '{32'h0000_0000, 1'b1, '{6'd0,  6'd51, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, '{6'd51, 6'd50, 1'b0}},
    '{32'h0000_0031, 1'b1, '{6'd49, 6'd49, 1'b0}},
    '{32'h8000_0000, 1'b0, '0},
    '{32'h0000_0001, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h0000_FFFF, 1'b0, '0},
    '{32'hFFFF_0000, 1'b0, '0},
    '{32'h0000_0034, 1'b0, '0},
    '{32'h1234_5678, 1'b0, '0},
    '{32'hDEAD_BEEF, 1'b0, '0},
    '{32'h0000_0002, 1'b0, '0},
    '{32'hFFFF_FFFE, 1'b0, '0},
    '{32'h0F0F_0F0F, 1'b0, '0},
    '{32'hF0F0_F0F0, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        sink_ready = 1'b0;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;

  cds_pkg::field_t deck_img [cds_pkg::DECK_SIZE];
  cds_pkg::addr_t  top_pos;
  deal_t           dealt_q [$];

  cds_in_if  word_if ();
  cds_out_if deal_if ();

  assign deal_if.ready = sink_ready;

  card_deck_shuffler i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_if),
    .out_o  (deal_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void add_deal(input deal_t d);
    dealt_q = {dealt_q, d};
  endfunction

  function automatic void deal_step(input cds_pkg::word_t w, input logic typed,
                                    input deal_t typed_first);
    cds_pkg::addr_t  j;
    cds_pkg::field_t held;
    deal_t           first;
    deal_t           second;
    j = cds_pkg::addr_t'(w % (cds_pkg::word_t'(top_pos) + 32'd1));
    held = deck_img[j];
    deck_img[j] = deck_img[top_pos];
    deck_img[top_pos] = held;
    first = '{deck_img[top_pos], cds_pkg::field_t'(top_pos), logic'(top_pos == '0)};
    add_deal(typed ? typed_first : first);
    if (top_pos == '0) begin
      top_pos = cds_pkg::TOP_POS;
    end else if (top_pos == cds_pkg::addr_t'(1)) begin
      second = '{deck_img[0], cds_pkg::field_t'(0), 1'b1};
      add_deal(second);
      top_pos = cds_pkg::TOP_POS;
    end else begin
      top_pos = top_pos - cds_pkg::addr_t'(1);
    end
  endfunction

  function automatic cds_pkg::word_t pick_word();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) return cds_pkg::word_t'($urandom);
    else if (kind < 8) return cds_pkg::word_t'($urandom_range(0, 63));
    else if (kind == 8) return ~cds_pkg::word_t'($urandom_range(0, 63));
    else return cds_pkg::word_t'(top_pos) * cds_pkg::word_t'($urandom_range(0, 3))
                + cds_pkg::word_t'(top_pos);
  endfunction

  function automatic void note_mismatch(input deal_t want, input deal_t got, input logic orphan);
    mismatches++;
    if (mismatches <= SHOW_MAX) begin
      if (orphan)
        $display("unexpected transaction: card %0d slot %0d pass_done %0d",
                 got.card, got.slot, got.pass_done);
      else
        $display("deal error: expected card %0d slot %0d pass_done %0d, got %0d %0d %0d",
                 want.card, want.slot, want.pass_done, got.card, got.slot, got.pass_done);
    end
  endfunction

  task automatic send_word(input cds_pkg::word_t w, input logic typed,
                           input deal_t typed_first);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      word_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    word_if.valid       <= 1'b1;
    word_if.random_word <= w;
    do @(posedge clk_i); while (!word_if.ready);
    deal_step(w, typed, typed_first);
  endtask

  always @(negedge clk_i) begin
    sink_ready <= rst_ni && (stall_left == 0);
  end

  always @(posedge clk_i) begin
    deal_t got;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("card_deck_shuffler: mismatch");
      $finish;
    end else if (rst_ni && deal_if.valid && deal_if.ready) begin
      got = '{deal_if.card, deal_if.slot, deal_if.pass_done};
      stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (dealt_q.size() == 0) begin
        note_mismatch('0, got, 1'b1);
      end else begin
        if (got !== dealt_q[0]) note_mismatch(dealt_q[0], got, 1'b0);
        void'(dealt_q.pop_front());
      end
    end else if (stall_left > 0) begin
      stall_left--;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    word_if.valid       = 1'b0;
    word_if.random_word = '0;
    for (int k = 0; k < cds_pkg::DECK_SIZE; k++) deck_img[k] = cds_pkg::field_t'(k);
    top_pos = cds_pkg::TOP_POS;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_word(DIR_TAB[i].word, DIR_TAB[i].typed, DIR_TAB[i].first);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 97 == 0) calm = ($urandom_range(0, 3) == 0);
      send_word(pick_word(), 1'b0, '0);
    end
    @(negedge clk_i);
    word_if.valid <= 1'b0;

    while (dealt_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("card_deck_shuffler: match");
    end else begin
      $display("card_deck_shuffler: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
hdl/cds_pkg.sv
hdl/cds_if.sv
hdl/cds_ram.sv
hdl/card_deck_shuffler.sv
sim/card_deck_shuffler_tb.sv
